>>> design/adamw_weight_update_macros.svh
// Assertion macros shared by the AdamW update design files.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ADAMW_WEIGHT_UPDATE_MACROS_SVH
`define ADAMW_WEIGHT_UPDATE_MACROS_SVH

// The consequent may carry a constant cycle delay.
`define AWU_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> cons) \
		else $error("implication check failed");

// The condition must never be true outside reset.
`define AWU_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("forbidden condition seen");

`endif

>>> design/awu_pkg.sv
// Shared types, constants and helpers for the AdamW weight update block.
// Depends on nothing; used by the step cells and the top level.
package awu_pkg;

	localparam int GDIV_STEPS = 32;
	localparam int SQRT_STEPS = 32;
	localparam int UDIV_STEPS = 34;
	localparam int LATENCY = 1 + GDIV_STEPS + 4 + SQRT_STEPS + 2 + UDIV_STEPS + 1;
	localparam int DEN_W = 41;

	localparam logic [24:0] ONE_Q24 = 25'h1000000;

	typedef enum logic [2:0] {
		REG_BETA_FIRST    = 3'd0,
		REG_BETA_SECOND   = 3'd1,
		REG_EPSILON       = 3'd2,
		REG_LEARNING_RATE = 3'd3,
		REG_DECAY_RATE    = 3'd4,
		REG_STEP_SIZE     = 3'd5,
		REG_BATCH_COUNT   = 3'd6
	} reg_idx_t;

	// Restoring division step state: remainder, numerator/quotient shifter, divisor.
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [63:0]      num;
		logic [DEN_W-1:0] den;
	} div_t;

	// Digit-by-digit square root step state.
	typedef struct packed {
		logic [32:0] rem;
		logic [31:0] root;
		logic [63:0] rad;
	} sqrt_t;

	// Item context while the gradient is divided.
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [31:0] m;
		logic [63:0]        v;
		logic               neg;
		logic               last;
	} gctx_t;

	// Item context once the moments are known.
	typedef struct packed {
		logic signed [31:0] w;
		logic signed [32:0] k;
		logic signed [31:0] m;
		logic [63:0]        v;
		logic               last;
		logic               ovf;
		logic               zero;
	} uctx_t;

	function automatic logic [31:0] sat32(input logic signed [39:0] x);
		logic [31:0] r;
		if (x > 40'sd2147483647)
			r = 32'h7fffffff;
		else if (x < -40'sd2147483648)
			r = 32'h80000000;
		else
			r = x[31:0];
		return r;
	endfunction

	function automatic logic [24:0] clamp_one(input logic [24:0] f);
		return (f > ONE_Q24) ? ONE_Q24 : f;
	endfunction

endpackage

>>> design/awu_div_cell.sv
// One restoring division step: produces one quotient bit per cycle.
// Depends on awu_pkg for the div_t step state.
module awu_div_cell import awu_pkg::*; (
	input  logic clk,
	input  div_t din,
	output div_t dout
);

	logic [DEN_W:0]   shifted;
	logic [DEN_W:0]   diff;
	logic             take;
	div_t             out_q;

	always_comb begin
		shifted = {din.rem, din.num[63]};
		diff = shifted - {1'b0, din.den};
		take = (shifted >= {1'b0, din.den});
	end

	always_ff @(posedge clk) begin
		out_q.rem <= take ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
		out_q.num <= {din.num[62:0], take};
		out_q.den <= din.den;
	end

	assign dout = out_q;

endmodule

>>> design/awu_sqrt_cell.sv
// One step of the integer square root: consumes two radicand bits per cycle.
// Depends on awu_pkg for the sqrt_t step state.
module awu_sqrt_cell import awu_pkg::*; (
	input  logic  clk,
	input  sqrt_t din,
	output sqrt_t dout
);

	logic [34:0] cur;
	logic [34:0] trial;
	logic [34:0] diff;
	logic        take;
	sqrt_t       out_q;

	always_comb begin
		cur = {din.rem, din.rad[63:62]};
		trial = {1'b0, din.root, 2'b01};
		diff = cur - trial;
		take = (cur >= trial);
	end

	always_ff @(posedge clk) begin
		out_q.rem <= take ? diff[32:0] : cur[32:0];
		out_q.root <= {din.root[30:0], take};
		out_q.rad <= {din.rad[61:0], 2'b00};
	end

	assign dout = out_q;

endmodule

>>> design/adamw_weight_update.sv
// AdamW weight update, one weight element per request, fully pipelined.
// Depends on awu_pkg, awu_div_cell, awu_sqrt_cell and the assertion macros.
//
// Usage. A request (weight_in, grad, first_moment_in, second_moment_in,
// last_element) is taken at every rising edge where start is high and busy is
// low. Busy is always low, so a new request can be issued in every cycle and
// the block sustains one element per clock. Each request yields exactly one
// result, shown on weight_out, first_moment_out, second_moment_out and
// last_out for a single cycle while done is high; the receiver cannot stall
// it. Results leave in request order. The latency is set by three rows of step
// cells: 32 cells that divide the gradient by the batch size, 32 cells that take
// the square root of the new second moment, and 34 cells that divide the step by
// the denominator, plus eight stages of multiplies and adds around them.
// The APB port holds the seven settings; change them only while no request is
// in flight. Reset clears all in-flight requests and restores the register
// defaults; no result appears until a new request has gone through.
`include "adamw_weight_update_macros.svh"

module adamw_weight_update import awu_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] weight_in,
	input  logic signed [31:0] grad,
	input  logic signed [31:0] first_moment_in,
	input  logic [63:0]        second_moment_in,
	input  logic               last_element,
	output logic               done,
	output logic signed [31:0] weight_out,
	output logic signed [31:0] first_moment_out,
	output logic [63:0]        second_moment_out,
	output logic               last_out,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	// Configuration registers.
	logic [24:0] beta_first_q;
	logic [24:0] beta_second_q;
	logic [31:0] epsilon_q;
	logic [31:0] learning_rate_q;
	logic [24:0] decay_rate_q;
	logic [31:0] step_size_q;
	logic [15:0] batch_count_q;
	logic [31:0] decay_p_q;

	logic        cfg_wr;
	reg_idx_t    cfg_idx;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign cfg_wr = psel & penable & pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_first_q <= 25'd15099494;
			beta_second_q <= 25'd16760439;
			epsilon_q <= 32'd43;
			learning_rate_q <= 32'd0;
			decay_rate_q <= 25'd167772;
			step_size_q <= 32'd0;
			batch_count_q <= 16'd1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				REG_BETA_FIRST: beta_first_q <= pwdata[24:0];
				REG_BETA_SECOND: beta_second_q <= pwdata[24:0];
				REG_EPSILON: epsilon_q <= pwdata;
				REG_LEARNING_RATE: learning_rate_q <= pwdata;
				REG_DECAY_RATE: decay_rate_q <= pwdata[24:0];
				REG_STEP_SIZE: step_size_q <= pwdata;
				REG_BATCH_COUNT: batch_count_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_BETA_FIRST: prdata = {7'd0, beta_first_q};
			REG_BETA_SECOND: prdata = {7'd0, beta_second_q};
			REG_EPSILON: prdata = epsilon_q;
			REG_LEARNING_RATE: prdata = learning_rate_q;
			REG_DECAY_RATE: prdata = {7'd0, decay_rate_q};
			REG_STEP_SIZE: prdata = step_size_q;
			REG_BATCH_COUNT: prdata = {16'd0, batch_count_q};
			default: prdata = 32'd0;
		endcase
	end

	// The combined decay factor only changes with the registers, so it is
	// refreshed every cycle and is settled long before a request needs it.
	logic [56:0] decay_prod;
	assign decay_prod = learning_rate_q * clamp_one(decay_rate_q) + 57'd8388608;
	always_ff @(posedge clk)
		decay_p_q <= decay_prod[55:24];

	logic [24:0] b1c;
	logic [24:0] cb1;
	logic [24:0] b2c;
	logic [24:0] cb2;
	assign b1c = clamp_one(beta_first_q);
	assign cb1 = ONE_Q24 - b1c;
	assign b2c = clamp_one(beta_second_q);
	assign cb2 = ONE_Q24 - b2c;

	// Stage 0: gradient magnitude plus half the batch, loaded into the divider row.
	logic        acc;
	logic [15:0] batch_n;
	logic [31:0] grad_mag;
	logic [31:0] grad_num;
	logic        vld_s0;
	div_t        div_s0;
	gctx_t       ctx_s0;

	assign acc = start & ~busy;
	assign batch_n = (batch_count_q == 16'd0) ? 16'd1 : batch_count_q;
	assign grad_mag = grad[31] ? $unsigned(-grad) : $unsigned(grad);
	assign grad_num = grad_mag + {17'd0, batch_n[15:1]};

	always_ff @(posedge clk) begin
		div_s0 <= '{rem: '0, num: {grad_num, 32'd0}, den: {25'd0, batch_n}};
		ctx_s0 <= '{w: weight_in, m: first_moment_in, v: second_moment_in,
			neg: grad[31], last: last_element};
	end

	// Gradient divider row.
	div_t                  gd [GDIV_STEPS+1];
	gctx_t                 gctx_q [GDIV_STEPS];
	logic [GDIV_STEPS-1:0] gvld_q;

	assign gd[0] = div_s0;
	for (genvar i = 0; i < GDIV_STEPS; i++) begin : g_gdiv
		awu_div_cell u_cell (.clk(clk), .din(gd[i]), .dout(gd[i+1]));
	end

	always_ff @(posedge clk) begin
		gctx_q[0] <= ctx_s0;
		for (int i = 1; i < GDIV_STEPS; i++)
			gctx_q[i] <= gctx_q[i-1];
	end

	// Stage 1: the first products of the moment update and the decay product.
	gctx_t              gc;
	logic [31:0]        gmag;
	logic signed [32:0] gsig;
	logic [31:0]        wmag1;

	assign gc = gctx_q[GDIV_STEPS-1];
	assign gmag = gd[GDIV_STEPS].num[31:0];
	assign gsig = gc.neg ? -$signed({1'b0, gmag}) : $signed({1'b0, gmag});
	assign wmag1 = gc.w[31] ? $unsigned(-gc.w) : $unsigned(gc.w);

	logic               vld_s1;
	logic signed [57:0] b1m_s1;
	logic signed [58:0] cg_s1;
	logic [63:0]        g2_s1;
	logic [56:0]        vlo_s1;
	logic [56:0]        vhi_s1;
	logic [63:0]        kp_s1;
	logic signed [31:0] w_s1;
	logic               last_s1;

	always_ff @(posedge clk) begin
		b1m_s1 <= $signed({1'b0, b1c}) * $signed(gc.m);
		cg_s1 <= $signed({1'b0, cb1}) * gsig;
		g2_s1 <= gmag * gmag;
		vlo_s1 <= gc.v[31:0] * b2c;
		vhi_s1 <= gc.v[63:32] * b2c;
		kp_s1 <= wmag1 * decay_p_q;
		w_s1 <= gc.w;
		last_s1 <= gc.last;
	end

	// Stage 2: new first moment, decay term, squared-gradient products.
	logic signed [59:0] msum;
	logic signed [35:0] mfl;
	logic [63:0]        kround;
	logic [31:0]        kmag;

	assign msum = 60'(b1m_s1) + 60'(cg_s1) + 60'sd8388608;
	assign mfl = 36'(msum >>> 24);
	assign kround = kp_s1 + 64'h80000000;
	assign kmag = kround[63:32];

	logic               vld_s2;
	logic signed [31:0] m_s2;
	logic signed [32:0] k_s2;
	logic [56:0]        g2lo_s2;
	logic [56:0]        g2hi_s2;
	logic [56:0]        vlo_s2;
	logic [56:0]        vhi_s2;
	logic signed [31:0] w_s2;
	logic               last_s2;

	always_ff @(posedge clk) begin
		m_s2 <= $signed(sat32(40'(mfl)));
		k_s2 <= w_s1[31] ? -$signed({1'b0, kmag}) : $signed({1'b0, kmag});
		g2lo_s2 <= g2_s1[31:0] * cb2;
		g2hi_s2 <= g2_s1[63:32] * cb2;
		vlo_s2 <= vlo_s1;
		vhi_s2 <= vhi_s1;
		w_s2 <= w_s1;
		last_s2 <= last_s1;
	end

	// Stage 3: high and low halves of the second moment sum.
	logic               vld_s3;
	logic [57:0]        hi_s3;
	logic [58:0]        lo_s3;
	logic signed [31:0] m_s3;
	logic signed [32:0] k_s3;
	logic signed [31:0] w_s3;
	logic               last_s3;

	always_ff @(posedge clk) begin
		hi_s3 <= 58'(vhi_s2) + 58'(g2hi_s2);
		lo_s3 <= 59'(vlo_s2) + 59'(g2lo_s2) + 59'd8388608;
		m_s3 <= m_s2;
		k_s3 <= k_s2;
		w_s3 <= w_s2;
		last_s3 <= last_s2;
	end

	// Stage 4: combine the halves, scale down and saturate the second moment.
	logic [90:0] vtot;
	logic [63:0] vnew;
	assign vtot = {1'b0, hi_s3, 32'd0} + 91'(lo_s3);
	assign vnew = (vtot[90:88] != 3'd0) ? 64'hffffffffffffffff : vtot[87:24];

	logic  vld_s4;
	uctx_t ctx_s4;

	always_ff @(posedge clk)
		ctx_s4 <= '{w: w_s3, k: k_s3, m: m_s3, v: vnew, last: last_s3,
			ovf: 1'b0, zero: 1'b0};

	// Square root row.
	sqrt_t                 sq [SQRT_STEPS+1];
	uctx_t                 sctx_q [SQRT_STEPS];
	logic [SQRT_STEPS-1:0] svld_q;

	assign sq[0] = '{rem: '0, root: '0, rad: ctx_s4.v};
	for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sqrt
		awu_sqrt_cell u_cell (.clk(clk), .din(sq[i]), .dout(sq[i+1]));
	end

	always_ff @(posedge clk) begin
		sctx_q[0] <= ctx_s4;
		for (int i = 1; i < SQRT_STEPS; i++)
			sctx_q[i] <= sctx_q[i-1];
	end

	// Stage 5: denominator and the step times the moment magnitude.
	uctx_t       sc;
	logic [31:0] mmag;
	assign sc = sctx_q[SQRT_STEPS-1];
	assign mmag = sc.m[31] ? $unsigned(-sc.m) : $unsigned(sc.m);

	logic             vld_s5;
	logic [DEN_W-1:0] den_s5;
	logic [63:0]      prod_s5;
	uctx_t            ctx_s5;

	always_ff @(posedge clk) begin
		den_s5 <= {1'b0, sq[SQRT_STEPS].root, 8'd0} + {9'd0, epsilon_q};
		prod_s5 <= step_size_q * mmag;
		ctx_s5 <= sc;
	end

	// Stage 6: add half the denominator for rounding and seed the step divider.
	// The quotient is only needed up to its limit of 2^33, so the top numerator
	// bits are compared against the divisor once instead of being divided out.
	logic [63:0] unum;
	assign unum = prod_s5 + 64'(den_s5 >> 1);

	logic  vld_s6;
	div_t  div_s6;
	uctx_t ctx_s6;

	always_ff @(posedge clk) begin
		div_s6 <= '{rem: DEN_W'(unum[63:34]), num: {unum[33:0], 30'd0}, den: den_s5};
		ctx_s6.w <= ctx_s5.w;
		ctx_s6.k <= ctx_s5.k;
		ctx_s6.m <= ctx_s5.m;
		ctx_s6.v <= ctx_s5.v;
		ctx_s6.last <= ctx_s5.last;
		ctx_s6.ovf <= (DEN_W'(unum[63:34]) >= den_s5);
		ctx_s6.zero <= (den_s5 == '0);
	end

	// Step divider row.
	div_t                  ud [UDIV_STEPS+1];
	uctx_t                 uctx_q [UDIV_STEPS];
	logic [UDIV_STEPS-1:0] uvld_q;

	assign ud[0] = div_s6;
	for (genvar i = 0; i < UDIV_STEPS; i++) begin : g_udiv
		awu_div_cell u_cell (.clk(clk), .din(ud[i]), .dout(ud[i+1]));
	end

	always_ff @(posedge clk) begin
		uctx_q[0] <= ctx_s6;
		for (int i = 1; i < UDIV_STEPS; i++)
			uctx_q[i] <= uctx_q[i-1];
	end

	// Stage 7: limit the step, apply decay and step to the weight, saturate.
	localparam logic [33:0] UMAX = 34'h200000000;
	uctx_t              uc;
	logic [33:0]        quo;
	logic [33:0]        umag;
	logic signed [34:0] upd;
	logic signed [36:0] wsum;

	assign uc = uctx_q[UDIV_STEPS-1];
	assign quo = ud[UDIV_STEPS].num[33:0];
	always_comb begin
		if (uc.zero)
			umag = '0;
		else if (uc.ovf || quo > UMAX)
			umag = UMAX;
		else
			umag = quo;
		upd = uc.m[31] ? -$signed({1'b0, umag}) : $signed({1'b0, umag});
		wsum = 37'($signed(uc.w)) - 37'($signed(uc.k)) - 37'(upd);
	end

	logic done_s7;
	logic last_s7;

	always_ff @(posedge clk) begin
		weight_out <= $signed(sat32(40'(wsum)));
		first_moment_out <= uc.m;
		second_moment_out <= uc.v;
	end

	// Valid flags of every stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
			gvld_q <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			svld_q <= '0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			uvld_q <= '0;
			done_s7 <= 1'b0;
			last_s7 <= 1'b0;
		end else begin
			vld_s0 <= acc;
			gvld_q <= {gvld_q[GDIV_STEPS-2:0], vld_s0};
			vld_s1 <= gvld_q[GDIV_STEPS-1];
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			svld_q <= {svld_q[SQRT_STEPS-2:0], vld_s4};
			vld_s5 <= svld_q[SQRT_STEPS-1];
			vld_s6 <= vld_s5;
			uvld_q <= {uvld_q[UDIV_STEPS-2:0], vld_s6};
			done_s7 <= uvld_q[UDIV_STEPS-1];
			last_s7 <= uvld_q[UDIV_STEPS-1] & uc.last;
		end
	end

	assign done = done_s7;
	assign last_out = last_s7;

	`AWU_ASSERT_IMPL(a_result_follows, clk, arst_n, start && !busy, ##LATENCY done)
	`AWU_ASSERT_IMPL(a_result_has_request, clk, arst_n, done, $past(start, LATENCY))
	`AWU_ASSERT_NEVER(a_last_without_done, clk, arst_n, last_out && !done)

endmodule
